// ----- rtl/free_list_pool_allocator_core_macros.svh -----
// Assertion macros for the pool allocator
`ifndef FREE_LIST_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FREE_LIST_POOL_ALLOCATOR_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define FLPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/flpa_pkg.sv -----
// Shared types and constants of the pool allocator
package flpa_pkg;
	localparam int POOL_UNITS   = 1024;
	localparam int HEADER_BYTES = 8;
	localparam int UW = $clog2(POOL_UNITS);
	localparam int SW = UW + 1;
	localparam int HB_SH = $clog2(HEADER_BYTES);
	localparam logic [SW:0] STEP_LIMIT = (SW+1)'(POOL_UNITS);

	typedef logic [UW-1:0] unit_t;
	typedef logic [SW-1:0] size_t;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_ARD   = 13'b0000000000010,
		ST_AWLK  = 13'b0000000000100,
		ST_ANXT  = 13'b0000000001000,
		ST_RRD   = 13'b0000000010000,
		ST_RWLK  = 13'b0000000100000,
		ST_RHP   = 13'b0000001000000,
		ST_RHN   = 13'b0000010000000,
		ST_RHW   = 13'b0000100000000,
		ST_RUPD  = 13'b0001000000000,
		ST_DONE  = 13'b0010000000000,
		ST_ACUT  = 13'b0100000000000,
		ST_AWT   = 13'b1000000000000
	} state_t;
endpackage

// ----- rtl/free_list_pool_allocator_core.sv -----
// Top level of the free list pool allocator
// Usage: a request is a transfer on the in channel (in_valid/in_ready) carrying
// kind, request_bytes and release_unit. kind 0 allocates the requested bytes
// plus one header unit first fit from the rover; kind 1 returns a block and
// merges it with free neighbors. Each request gives exactly one result transfer
// on the out channel (out_valid/out_ready): granted_unit and success.
// Requests are served one at a time. The free list lives in two header
// memories with a registered read; each step of the walk sets the read
// address, then uses the data. An allocate that splits a free block writes
// the header of the cut part in an extra step; a release reads the headers
// of the freed block and its successor before it updates the list; a
// release of unit 0 fails at once, without a walk.
// The result sits in an output register; a new request is taken only after
// the previous result has been handed over, so a stalled receiver holds the
// block at the finished result.
// Reset clears control state and the rover; the two header entries the pool
// starts with (sentinel at unit 0, one free block at unit 1) are held in
// registers until first written, so no clearing pass is needed.
`include "free_list_pool_allocator_core_macros.svh"
module free_list_pool_allocator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic kind,
	input  logic [13:0] request_bytes,
	input  logic [9:0] release_unit,
	output logic out_valid,
	input  logic out_ready,
	output logic [9:0] granted_unit,
	output logic success
);
	import flpa_pkg::*;

	unit_t nxt_mem [POOL_UNITS];
	size_t siz_mem [POOL_UNITS];
	logic init0n_q, init0s_q, init1n_q, init1s_q;

	state_t st_q;
	unit_t raddr_q, rd_addr_q;
	unit_t nrd_q;
	size_t srd_q;
	logic we_n, we_s;
	unit_t wa_n, wa_s;
	unit_t wd_n;
	size_t wd_s;

	unit_t rover_q, wrk_q, ptr_q, nxt_q, pn_q, nn_q;
	size_t units_q, ps_q, ns_q, ws_q;
	logic [SW:0] steps_q;
	logic kind_q;
	logic [9:0] gu_q;
	logic ok_q, ov_q;

	unit_t rn;
	size_t rs;
	always_comb begin
		rn = nrd_q;
		rs = srd_q;
		if (rd_addr_q == '0) begin
			if (!init0n_q) rn = unit_t'(1);
			if (!init0s_q) rs = '0;
		end else if (rd_addr_q == unit_t'(1)) begin
			if (!init1n_q) rn = '0;
			if (!init1s_q) rs = size_t'(POOL_UNITS - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (we_n) nxt_mem[wa_n] <= wd_n;
		if (we_s) siz_mem[wa_s] <= wd_s;
		nrd_q <= nxt_mem[raddr_q];
		srd_q <= siz_mem[raddr_q];
		rd_addr_q <= raddr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0n_q <= 1'b0;
			init0s_q <= 1'b0;
			init1n_q <= 1'b0;
			init1s_q <= 1'b0;
		end else begin
			if (we_n && wa_n == '0) init0n_q <= 1'b1;
			if (we_s && wa_s == '0) init0s_q <= 1'b1;
			if (we_n && wa_n == unit_t'(1)) init1n_q <= 1'b1;
			if (we_s && wa_s == unit_t'(1)) init1s_q <= 1'b1;
		end
	end

	logic [14:0] bytes1;
	logic [14:0] ucalc_w;
	size_t ucalc;
	assign bytes1 = (request_bytes == '0) ? 15'd1 : {1'b0, request_bytes};
	assign ucalc_w = ((bytes1 + 15'(HEADER_BYTES - 1)) >> HB_SH) + 15'd1;
	assign ucalc = (ucalc_w > 15'(2**SW - 1)) ? '1 : ucalc_w[SW-1:0];

	logic in_rng;
	assign in_rng = ptr_q > wrk_q && ptr_q < rn;
	logic wrap_rng;
	assign wrap_rng = wrk_q >= rn && (ptr_q > wrk_q || ptr_q < rn);

	logic adj_up, adj_dn;
	assign adj_up = ((SW+1)'(ptr_q) + (SW+1)'(ps_q)) == (SW+1)'(nxt_q);
	assign adj_dn = ((SW+1)'(wrk_q) + (SW+1)'(ws_q)) == (SW+1)'(ptr_q);

	unit_t carve;
	assign carve = unit_t'(ptr_q + (rs - units_q));

	assign in_ready = (st_q == ST_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign granted_unit = gu_q;
	assign success = ok_q;

	always_comb begin
		we_n = 1'b0; we_s = 1'b0;
		wa_n = '0; wa_s = '0; wd_n = '0; wd_s = '0;
		case (st_q)
			ST_AWLK: begin
				if (rs >= units_q && steps_q <= STEP_LIMIT) begin
					if (rs == units_q) begin
						we_n = 1'b1; wa_n = wrk_q; wd_n = rn;
					end else begin
						we_s = 1'b1; wa_s = ptr_q; wd_s = rs - units_q;
					end
				end
			end
			ST_ACUT: begin
				we_s = 1'b1; wa_s = ptr_q; wd_s = units_q;
			end
			ST_RUPD: begin
				we_n = 1'b1; wa_n = ptr_q;
				if (adj_up) begin
					we_s = 1'b1; wa_s = ptr_q; wd_s = ps_q + ns_q; wd_n = nn_q;
				end else
					wd_n = nxt_q;
			end
			ST_DONE: begin
				if (kind_q == KIND_RELEASE) begin
					we_n = 1'b1; wa_n = wrk_q;
					if (adj_dn) begin
						we_s = 1'b1; wa_s = wrk_q; wd_s = ws_q + ps_q; wd_n = pn_q;
					end else
						wd_n = ptr_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rover_q <= '0;
			ov_q <= 1'b0;
			raddr_q <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					kind_q <= kind;
					units_q <= ucalc;
					wrk_q <= rover_q;
					steps_q <= '0;
					raddr_q <= rover_q;
					ptr_q <= release_unit - 10'd1;
					if (kind == KIND_ALLOC) st_q <= ST_AWT;
					else if (release_unit == '0) begin
						gu_q <= '0; ok_q <= 1'b0; ov_q <= 1'b1;
					end else st_q <= ST_RRD;
				end
				ST_AWT: st_q <= ST_ARD;
				ST_ARD: begin
					ptr_q <= rn;
					raddr_q <= rn;
					st_q <= ST_ANXT;
				end
				ST_ANXT: st_q <= ST_AWLK;
				ST_AWLK: begin
					if (steps_q > STEP_LIMIT) begin
						gu_q <= '0; ok_q <= 1'b0; ov_q <= 1'b1; st_q <= ST_IDLE;
					end else if (rs >= units_q) begin
						rover_q <= wrk_q;
						ok_q <= 1'b1;
						if (rs == units_q) begin
							gu_q <= 10'(ptr_q + unit_t'(1));
							ov_q <= 1'b1; st_q <= ST_IDLE;
						end else begin
							ptr_q <= carve;
							st_q <= ST_ACUT;
						end
					end else if (ptr_q == rover_q) begin
						gu_q <= '0; ok_q <= 1'b0; ov_q <= 1'b1; st_q <= ST_IDLE;
					end else begin
						wrk_q <= ptr_q;
						ptr_q <= rn;
						raddr_q <= rn;
						steps_q <= steps_q + 1'b1;
						st_q <= ST_ANXT;
					end
				end
				ST_ACUT: begin
					gu_q <= 10'(ptr_q + unit_t'(1));
					ov_q <= 1'b1; st_q <= ST_IDLE;
				end
				ST_RRD: st_q <= ST_RWLK;
				ST_RWLK: begin
					if (in_rng || wrap_rng || steps_q > STEP_LIMIT) begin
						ws_q <= rs; nxt_q <= rn;
						raddr_q <= ptr_q; st_q <= ST_RHP;
					end else begin
						wrk_q <= rn; raddr_q <= rn;
						steps_q <= steps_q + 1'b1;
						st_q <= ST_RRD;
					end
				end
				ST_RHP: begin
					raddr_q <= nxt_q; st_q <= ST_RHN;
				end
				ST_RHN: begin
					ps_q <= rs; pn_q <= rn; st_q <= ST_RHW;
				end
				ST_RHW: begin
					ns_q <= rs; nn_q <= rn; st_q <= ST_RUPD;
				end
				ST_RUPD: begin
					if (adj_up) begin
						ps_q <= ps_q + ns_q; pn_q <= nn_q;
					end else pn_q <= nxt_q;
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					rover_q <= wrk_q;
					gu_q <= '0; ok_q <= 1'b1; ov_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`FLPA_ASSERT_IMP(a_no_take_busy, clk, arst_n, in_valid && in_ready, !out_valid)
	`FLPA_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid && !success, granted_unit == '0)
	`FLPA_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(granted_unit) && $stable(success))
endmodule

// ----- bench/tb_free_list_pool_allocator_core.sv -----
// Testbench for the free list pool allocator: predicted results checked against the block
module tb_free_list_pool_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import flpa_pkg::*;

	typedef struct {
		logic        kind;
		logic [13:0] bytes;
		logic [9:0]  unit;
		logic [9:0]  want_unit;
		logic        want_ok;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_ALLOC;
	logic [13:0] request_bytes = '0;
	logic [9:0] release_unit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [9:0] granted_unit;
	logic success;

	req_t reqs[$];
	req_t grants_due[$];
	int unsigned nxt = 0;
	int unsigned taken = 0;
	int errors = 0;

	int unsigned blk_next[POOL_UNITS];
	int unsigned blk_size[POOL_UNITS];
	int unsigned rov;
	logic [9:0] live_blocks[$];

	free_list_pool_allocator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .request_bytes(request_bytes), .release_unit(release_unit),
		.out_valid(out_valid), .out_ready(out_ready),
		.granted_unit(granted_unit), .success(success)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned wrapu(int unsigned u);
		return u % POOL_UNITS;
	endfunction

	function automatic void carve(input int unsigned nbytes, output logic [9:0] gu,
			output logic ok);
		int unsigned units, wrk, ptr;
		gu = '0;
		ok = 1'b0;
		if (nbytes == 0) nbytes = 1;
		units = (nbytes + HEADER_BYTES - 1) / HEADER_BYTES + 1;
		wrk = rov;
		ptr = wrapu(blk_next[wrk]);
		for (int s = 0; s <= POOL_UNITS; s++) begin
			if (blk_size[ptr] >= units) begin
				if (blk_size[ptr] == units) begin
					blk_next[wrk] = blk_next[ptr];
				end else begin
					blk_size[ptr] -= units;
					ptr = wrapu(ptr + blk_size[ptr]);
					blk_size[ptr] = units;
				end
				rov = wrk;
				gu = 10'(ptr + 1);
				ok = 1'b1;
				return;
			end
			if (ptr == rov) return;
			wrk = ptr;
			ptr = wrapu(blk_next[ptr]);
		end
	endfunction

	function automatic logic give_back(int unsigned du);
		int unsigned ptr, wrk, nx;
		if (du == 0 || du >= POOL_UNITS) return 1'b0;
		ptr = du - 1;
		wrk = rov;
		for (int s = 0; s <= POOL_UNITS; s++) begin
			nx = wrapu(blk_next[wrk]);
			if (ptr > wrk && ptr < nx) break;
			if (wrk >= nx && (ptr > wrk || ptr < nx)) break;
			wrk = nx;
		end
		nx = wrapu(blk_next[wrk]);
		if (ptr + blk_size[ptr] == nx) begin
			blk_size[ptr] += blk_size[nx];
			blk_next[ptr] = wrapu(blk_next[nx]);
		end else begin
			blk_next[ptr] = nx;
		end
		if (wrk + blk_size[wrk] == ptr) begin
			blk_size[wrk] += blk_size[ptr];
			blk_next[wrk] = blk_next[ptr];
		end else begin
			blk_next[wrk] = ptr;
		end
		rov = wrk;
		return 1'b1;
	endfunction

	task automatic add_alloc(input int unsigned nbytes);
		req_t r;
		r.kind = KIND_ALLOC;
		r.bytes = 14'(nbytes);
		r.unit = 10'($urandom);
		carve(nbytes, r.want_unit, r.want_ok);
		if (r.want_ok) live_blocks.push_back(r.want_unit);
		reqs.push_back(r);
	endtask

	task automatic add_release(input logic [9:0] du);
		req_t r;
		r.kind = KIND_RELEASE;
		r.bytes = 14'($urandom);
		r.unit = du;
		r.want_unit = '0;
		r.want_ok = give_back(du);
		reqs.push_back(r);
	endtask

	task automatic add_release_live();
		int i;
		logic [9:0] du;
		i = $urandom_range(live_blocks.size() - 1);
		du = live_blocks[i];
		live_blocks.delete(i);
		add_release(du);
	endtask

	function automatic int unsigned pick_bytes();
		int p;
		p = $urandom_range(99);
		if (p < 75) return $urandom_range(200);
		if (p < 95) return $urandom_range(2000);
		return $urandom_range(8192);
	endfunction

	function automatic int stage();
		if (taken < 250) return 0;
		if (taken < 500) return 1;
		return 2;
	endfunction

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			grants_due.push_back(reqs[nxt]);
			nxt <= nxt + 1;
			taken <= taken + 1;
		end
		if (out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				errors++;
				$display("%t: unexpected transfer unit %0d success %0b",
					$time, granted_unit, success);
			end else begin
				if (granted_unit !== grants_due[0].want_unit) begin
					errors++;
					$display("%t: granted_unit expected %0d actual %0d",
						$time, grants_due[0].want_unit, granted_unit);
				end
				if (success !== grants_due[0].want_ok) begin
					errors++;
					$display("%t: success expected %0b actual %0b",
						$time, grants_due[0].want_ok, success);
				end
				void'(grants_due.pop_front());
			end
		end
	end

	int unsigned shown = 32'hFFFF_FFFF;

	always @(negedge clk) begin
		int rp;
		rp = (stage() == 0) ? 77 : (stage() == 1) ? 20 : 0;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= rp);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && shown == nxt) begin
		end else if (nxt < reqs.size()
				&& $urandom_range(99) >= ((stage() == 0) ? 20 :
					(stage() == 1) ? 77 : 0)) begin
			kind <= reqs[nxt].kind;
			request_bytes <= reqs[nxt].bytes;
			release_unit <= reqs[nxt].unit;
			in_valid <= 1'b1;
			shown = nxt;
		end else begin
			in_valid <= 1'b0;
			shown = 32'hFFFF_FFFF;
		end
	end

	initial begin
		int total;
		for (int u = 0; u < POOL_UNITS; u++) begin
			blk_next[u] = 0;
			blk_size[u] = 0;
		end
		blk_next[0] = 1;
		blk_size[1] = POOL_UNITS - 1;
		rov = 0;
		add_alloc(0);
		add_alloc(1);
		add_alloc(8192);
		add_alloc(8184);
		add_release(10'd0);
		add_alloc(8);
		add_alloc(9);
		add_alloc(100);
		add_release(live_blocks[1]);
		live_blocks.delete(1);
		add_alloc(8);
		add_alloc(7000);
		add_alloc(8192);
		add_release_live();
		add_release_live();
		add_alloc(16);
		while (live_blocks.size() > 0) add_release_live();
		add_alloc(8168);
		add_alloc(0);
		add_release_live();
		add_release(10'd0);
		total = reqs.size() + 750;
		while (reqs.size() < total) begin
			if (live_blocks.size() == 0 || ($urandom_range(99) < 55 && live_blocks.size() < 60))
				add_alloc(pick_bytes());
			else if ($urandom_range(99) < 3)
				add_release(10'd0);
			else
				add_release_live();
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (nxt == reqs.size() && grants_due.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && grants_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ----- free_list_pool_allocator_core.f -----
+incdir+rtl
rtl/flpa_pkg.sv
rtl/free_list_pool_allocator_core.sv
bench/tb_free_list_pool_allocator_core.sv
